// ===== rtl/pce_pkg.sv =====
// Shared types, register indexes and a helper function for the punctured encoder.
`default_nettype none

package pce_pkg;

	localparam int GEN_W   = 7;
	localparam int STEAL_W = 4;
	localparam int CFG_AW  = 2;
	localparam int CFG_DW  = 7;

	// Register indexes on the configuration channel
	localparam logic [CFG_AW-1:0] CFG_STEAL_PERIOD = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_GEN_POLY_A   = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_GEN_POLY_B   = 2'd2;

	localparam logic [STEAL_W-1:0] STEAL_RST  = 4'd0;
	localparam logic [STEAL_W-1:0] STEAL_TWO  = 4'd2;
	localparam logic [STEAL_W-1:0] STEAL_PLAIN_MAX = 4'd1;
	localparam logic [GEN_W-1:0]   GEN_A_RST  = 7'd91;
	localparam logic [GEN_W-1:0]   GEN_B_RST  = 7'd121;

	// A period of at least two shifted up by three exceeds any 4-bit count,
	// so compares against period << 2, << 1 and << 0 reach the remainder
	localparam int CNT_REDUCE_STEPS = 3;

	typedef struct packed {
		logic data_bit;
	} pce_in_t;

	typedef struct packed {
		logic coded_bit;
		logic bit_taken;
	} pce_out_t;

	typedef struct packed {
		logic [CFG_AW-1:0] addr;
		logic [CFG_DW-1:0] wdata;
	} pce_cfg_t;

	// Count reduced modulo the period by shifted compare and subtract (period >= 2)
	function automatic logic [STEAL_W-1:0] cnt_reduce(input logic [STEAL_W-1:0] cnt,
		input logic [STEAL_W-1:0] period);
		logic [2*STEAL_W-1:0] r;
		logic [2*STEAL_W-1:0] d;
		r = {{STEAL_W{1'b0}}, cnt};
		for (int s = CNT_REDUCE_STEPS - 1; s >= 0; s--) begin
			d = {{STEAL_W{1'b0}}, period} << s;
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[STEAL_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pce_intf.sv =====
// Valid/ready channel interfaces for data input, coded output and configuration.
`default_nettype none

interface pce_in_if;
	import pce_pkg::*;
	logic    valid;
	logic    ready;
	pce_in_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface pce_out_if;
	import pce_pkg::*;
	logic     valid;
	logic     ready;
	pce_out_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface pce_cfg_if;
	import pce_pkg::*;
	logic     valid;
	logic     ready;
	pce_cfg_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/pce_core.sv =====
// Encoder state, configuration registers and the combinational encode step.
`default_nettype none

module pce_core #(
	parameter int CONSTRAINT_LENGTH = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire pce_pkg::pce_in_t  item,
	input  wire logic              cfg_we,
	input  wire pce_pkg::pce_cfg_t cfg_wr,
	output pce_pkg::pce_out_t      result
);
	import pce_pkg::*;

	localparam int K = CONSTRAINT_LENGTH;

	logic [K-1:0]       sr_q, sr_n;
	logic               phase_q, phase_n;
	logic               fetch_q, fetch_n;
	logic [STEAL_W-1:0] cnt_q, cnt_n;
	logic [STEAL_W-1:0] steal_q;
	logic [GEN_W-1:0]   poly_a_q, poly_b_q;

	logic [K-1:0]       poly_a_k, poly_b_k;
	logic               punct;
	logic [STEAL_W-1:0] cnt_red;
	logic [STEAL_W:0]   cnt_inc;
	logic               taken;

	// Fit the 7-bit masks to the register: extra mask bits drop, missing ones are zero
	for (genvar i = 0; i < K; i++) begin : g_mask
		if (i < GEN_W) begin : g_in
			assign poly_a_k[i] = poly_a_q[i];
			assign poly_b_k[i] = poly_b_q[i];
		end else begin : g_out
			assign poly_a_k[i] = 1'b0;
			assign poly_b_k[i] = 1'b0;
		end
	end

	always_comb begin
		punct   = steal_q > STEAL_PLAIN_MAX;
		cnt_red = cnt_reduce(cnt_q, steal_q);
		cnt_inc = {1'b0, cnt_red} + {{STEAL_W{1'b0}}, 1'b1};
		sr_n    = sr_q;
		fetch_n = fetch_q;
		cnt_n   = cnt_q;
		taken   = 1'b0;
		if (punct) begin
			if (fetch_q) begin
				sr_n    = {sr_q[K-2:0], item.data_bit};
				taken   = 1'b1;
				fetch_n = cnt_red != '0;
				cnt_n   = (cnt_inc >= {1'b0, steal_q}) ? '0 : cnt_inc[STEAL_W-1:0];
			end else begin
				fetch_n = 1'b1;
			end
		end else begin
			if (phase_q) begin
				sr_n  = {sr_q[K-2:0], item.data_bit};
				taken = 1'b1;
			end
			cnt_n = '0;
		end
		phase_n = ~phase_q;
		if (fetch_n && (steal_q == STEAL_TWO)) begin
			phase_n = 1'b1;
		end
		result.coded_bit = ^(sr_n & (phase_q ? poly_a_k : poly_b_k));
		result.bit_taken = taken;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q    <= '0;
			phase_q <= 1'b1;
			fetch_q <= 1'b1;
			cnt_q   <= '0;
		end else if (step) begin
			sr_q    <= sr_n;
			phase_q <= phase_n;
			fetch_q <= fetch_n;
			cnt_q   <= cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steal_q  <= STEAL_RST;
			poly_a_q <= GEN_A_RST;
			poly_b_q <= GEN_B_RST;
		end else if (cfg_we) begin
			case (cfg_wr.addr)
				CFG_STEAL_PERIOD: steal_q  <= cfg_wr.wdata[STEAL_W-1:0];
				CFG_GEN_POLY_A:   poly_a_q <= cfg_wr.wdata[GEN_W-1:0];
				CFG_GEN_POLY_B:   poly_b_q <= cfg_wr.wdata[GEN_W-1:0];
				default: ;
			endcase
		end
	end

	a_plain_clears_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		step && !punct |=> cnt_q == '0)
		else $error("count not cleared in rate-1/2 mode");

	a_plain_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		step && !punct |=> phase_q != $past(phase_q))
		else $error("phase did not toggle in rate-1/2 mode");

	a_skip_sets_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		step && punct && !fetch_q |=> fetch_q)
		else $error("fetch flag not set after a punctured skip");

endmodule

`default_nettype wire

// ===== rtl/pce_obuf.sv =====
// Two-entry output buffer (main register plus skid) for coded results.
`default_nettype none

module pce_obuf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire pce_pkg::pce_out_t push_data,
	output logic                   push_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pce_pkg::pce_out_t      out_data
);
	import pce_pkg::*;

	logic     main_valid_q, skid_valid_q;
	pce_out_t main_q, skid_q;
	logic     pop;

	assign push_ready = !skid_valid_q;
	assign pop        = main_valid_q && out_ready;
	assign out_valid  = main_valid_q;
	assign out_data   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry held while main entry empty");

	a_full_push_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		push && main_valid_q && !pop |=> skid_valid_q)
		else $error("result dropped on push into a stalled buffer");

	a_skid_refills_main: assert property (@(posedge clk) disable iff (!arst_n)
		pop && skid_valid_q |=> main_valid_q && !skid_valid_q)
		else $error("skid entry not moved to main on pop");

endmodule

`default_nettype wire

// ===== rtl/punctured_conv_encoder.sv =====
// Top level of the punctured convolutional encoder.
//
// Channels:
//   data_in  - one transaction per requested coded bit; carries a candidate data_bit
//              that is shifted into the encoder only when the encoder fetches.
//   code_out - one transaction per input transaction: coded_bit and bit_taken.
//   cfg      - register writes (0 steal_period, 1 gen_poly_a, 2 gen_poly_b);
//              always ready, write only while the encoder is idle.
// Output: a result is registered in the output buffer before it is visible on code_out.
// Throughput: one item per clock while the output buffer has room; the step is one
//   shift plus a masked parity between the state registers and the output buffer.
// Stall: a two-entry output buffer lets data_in keep accepting while a result
//   waits; data_in.ready drops only once both entries are full.
// Reset (arst_n low): shift register zero, phase and fetch flags set, count zero,
//   steal_period 0, gen_poly_a 91, gen_poly_b 121, output buffer empty.
`default_nettype none

module punctured_conv_encoder #(
	parameter int CONSTRAINT_LENGTH = 7
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pce_in_if.sink     data_in,
	pce_out_if.source  code_out,
	pce_cfg_if.sink    cfg
);
	import pce_pkg::*;

	logic     step;
	logic     buf_ready;
	pce_out_t result;

	// Item accepted whenever the output buffer has room
	assign data_in.ready = buf_ready;
	assign step          = data_in.valid && buf_ready;
	assign cfg.ready     = 1'b1;

	pce_core #(
		.CONSTRAINT_LENGTH(CONSTRAINT_LENGTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (data_in.payload),
		.cfg_we (cfg.valid),
		.cfg_wr (cfg.payload),
		.result (result)
	);

	pce_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (step),
		.push_data  (result),
		.push_ready (buf_ready),
		.out_valid  (code_out.valid),
		.out_ready  (code_out.ready),
		.out_data   (code_out.payload)
	);

endmodule

`default_nettype wire
